// ===== src/ett_pkg.sv =====
// ett_pkg: shared types, field widths and codes for the expiring timer table
// used by ett_slots, expiring_timer_table and ett_checker; no dependencies
package ett_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int TIME_W  = 32;
    localparam int TAG_W   = 16;
    localparam int FIELD_W = 4;

    typedef logic [SLOT_W-1:0]  t_slot_idx;
    typedef logic [FIELD_W-1:0] t_slot_field;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [TAG_W-1:0]   t_tag;

    localparam t_slot_idx LAST_IDX = t_slot_idx'(SLOTS - 1);

    typedef enum logic [1:0] {
        MODE_ADD          = 2'd0,
        MODE_ADD_DEFERRED = 2'd1,
        MODE_CANCEL       = 2'd2,
        MODE_TICK         = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ADDED      = 3'd0,
        KIND_REJECTED   = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_DONE       = 3'd3,
        KIND_CANCEL_ACK = 3'd4
    } t_kind;

    typedef struct packed {
        t_slot_idx q_addr;
        logic      rd_en;
        t_slot_idx rd_addr;
        logic      wr_en;
        t_slot_idx wr_addr;
        t_time     wr_expiry;
        t_tag      wr_tag;
        logic      wr_wait;
        logic      cancel_en;
        t_slot_idx cancel_addr;
        logic      free_en;
        t_slot_idx free_addr;
        logic      end_scan;
    } t_slot_cmd;

    typedef struct packed {
        logic in_use;
        logic waiting;
        logic cancelled;
    } t_slot_flags;

endpackage

// ===== src/ett_slots.sv =====
// ett_slots: timer storage, expiry and tag memory with registered read plus per-slot flags
// depends on ett_pkg
module ett_slots (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ett_pkg::t_slot_cmd  i_cmd,
    output ett_pkg::t_slot_flags o_flags,
    output ett_pkg::t_time      o_rd_expiry,
    output ett_pkg::t_tag       o_rd_tag
);

    logic [ett_pkg::TIME_W+ett_pkg::TAG_W-1:0] r_mem [ett_pkg::SLOTS];
    logic [ett_pkg::TIME_W+ett_pkg::TAG_W-1:0] r_rd_word;
    logic [ett_pkg::SLOTS-1:0] r_in_use;
    logic [ett_pkg::SLOTS-1:0] r_waiting;
    logic [ett_pkg::SLOTS-1:0] r_cancelled;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= {i_cmd.wr_expiry, i_cmd.wr_tag};
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_waiting   <= '0;
            r_cancelled <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_in_use[i_cmd.wr_addr]    <= 1'b1;
                r_cancelled[i_cmd.wr_addr] <= 1'b0;
                r_waiting[i_cmd.wr_addr]   <= i_cmd.wr_wait;
            end
            if (i_cmd.cancel_en && r_in_use[i_cmd.cancel_addr]) begin
                r_cancelled[i_cmd.cancel_addr] <= 1'b1;
            end
            if (i_cmd.free_en) begin
                r_in_use[i_cmd.free_addr]    <= 1'b0;
                r_cancelled[i_cmd.free_addr] <= 1'b0;
            end
            if (i_cmd.end_scan) begin
                r_waiting <= '0;
            end
        end
    end

    assign o_flags.in_use    = r_in_use[i_cmd.q_addr];
    assign o_flags.waiting   = r_waiting[i_cmd.q_addr];
    assign o_flags.cancelled = r_cancelled[i_cmd.q_addr];
    assign o_rd_expiry = r_rd_word[ett_pkg::TIME_W+ett_pkg::TAG_W-1:ett_pkg::TAG_W];
    assign o_rd_tag    = r_rd_word[ett_pkg::TAG_W-1:0];

endmodule

// ===== src/expiring_timer_table.sv =====
// expiring_timer_table: top level, command sequencer and result register
// depends on ett_pkg and ett_slots
//
// usage
// - input channel i_in_valid / o_in_ready carries one command word: add, deferred
//   add, cancel or tick scan; output channel o_out_valid / i_out_ready carries
//   result words, the last one of each command flagged by o_last
// - one command is worked on at a time; o_in_ready is high while the sequencer
//   is idle, also while a result still sits in the output register
// - add: an accept step, then a walk over the in-use flags from slot 0 until a
//   free slot is found; one result word, rejected if full or on expiry overflow
// - cancel: one acknowledge word
// - tick scan: one memory read per slot; one fired word per expired live
//   timer, then the done word
// - results leave through one output register, first word in the cycle after
//   the work that makes it; a stalled receiver holds the sequencer in place
//   while it has a word to emit, until the register frees up; nothing is dropped
// - reset clears all slot flags and the output valid bit; expiry and tag
//   storage needs no clearing, it is only used for slots in use
module expiring_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_delay,
    input  logic [15:0] i_callback_tag,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_current_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot_res,
    output logic [15:0] o_callback_tag_res,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CANCEL,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    ett_pkg::t_slot_idx    r_idx, n_idx;
    ett_pkg::t_time        r_expiry, n_expiry;
    logic                  r_wrap, n_wrap;
    logic                  r_wait, n_wait;
    ett_pkg::t_tag         r_tag_in, n_tag_in;
    ett_pkg::t_slot_field  r_slot_in, n_slot_in;
    ett_pkg::t_time        r_now, n_now;

    logic                  r_o_valid, n_o_valid;
    ett_pkg::t_kind        r_kind, n_kind;
    ett_pkg::t_slot_field  r_slot_res, n_slot_res;
    ett_pkg::t_tag         r_tag_res, n_tag_res;
    logic                  r_last, n_last;

    ett_pkg::t_slot_cmd    cmd;
    ett_pkg::t_slot_flags  flags;
    ett_pkg::t_time        rd_expiry;
    ett_pkg::t_tag         rd_tag;

    logic out_free;
    logic hit;
    logic fire;

    ett_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_rd_expiry (rd_expiry),
        .o_rd_tag    (rd_tag)
    );

    assign out_free = !r_o_valid || i_out_ready;
    assign hit      = flags.in_use && !flags.waiting && (rd_expiry <= r_now);
    assign fire     = hit && !flags.cancelled;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_expiry   = r_expiry;
        n_wrap     = r_wrap;
        n_wait     = r_wait;
        n_tag_in   = r_tag_in;
        n_slot_in  = r_slot_in;
        n_now      = r_now;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_kind     = r_kind;
        n_slot_res = r_slot_res;
        n_tag_res  = r_tag_res;
        n_last     = r_last;

        cmd           = '0;
        cmd.q_addr    = r_idx;
        cmd.wr_addr   = r_idx;
        cmd.wr_expiry = r_expiry;
        cmd.wr_tag    = r_tag_in;
        cmd.wr_wait   = r_wait;
        cmd.free_addr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now               = i_current_time;
                    n_tag_in            = i_callback_tag;
                    n_slot_in           = i_slot;
                    {n_wrap, n_expiry}  = {1'b0, i_delay} + {1'b0, i_current_time};
                    n_wait              = (i_mode == ett_pkg::MODE_ADD_DEFERRED);
                    n_idx               = '0;
                    unique case (ett_pkg::t_mode'(i_mode)) inside
                        ett_pkg::MODE_ADD, ett_pkg::MODE_ADD_DEFERRED: begin
                            n_state = S_ADD;
                        end
                        ett_pkg::MODE_CANCEL: begin
                            n_state = S_CANCEL;
                        end
                        ett_pkg::MODE_TICK: begin
                            n_state     = S_SCAN;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (out_free) begin
                    if (r_wrap || (flags.in_use && r_idx == ett_pkg::LAST_IDX)) begin
                        n_o_valid  = 1'b1;
                        n_kind     = ett_pkg::KIND_REJECTED;
                        n_slot_res = '0;
                        n_tag_res  = '0;
                        n_last     = 1'b1;
                        n_state    = S_IDLE;
                    end else if (!flags.in_use) begin
                        cmd.wr_en  = 1'b1;
                        n_o_valid  = 1'b1;
                        n_kind     = ett_pkg::KIND_ADDED;
                        n_slot_res = ett_pkg::t_slot_field'(r_idx);
                        n_tag_res  = '0;
                        n_last     = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + ett_pkg::t_slot_idx'(1);
                    end
                end
            end
            S_CANCEL: begin
                if (out_free) begin
                    cmd.cancel_en   = (int'(r_slot_in) < ett_pkg::SLOTS);
                    cmd.cancel_addr = ett_pkg::t_slot_idx'(r_slot_in);
                    n_o_valid       = 1'b1;
                    n_kind          = ett_pkg::KIND_CANCEL_ACK;
                    n_slot_res      = r_slot_in;
                    n_tag_res       = '0;
                    n_last          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!fire || out_free) begin
                    cmd.free_en = hit;
                    if (fire) begin
                        n_o_valid  = 1'b1;
                        n_kind     = ett_pkg::KIND_FIRED;
                        n_slot_res = ett_pkg::t_slot_field'(r_idx);
                        n_tag_res  = rd_tag;
                        n_last     = 1'b0;
                    end
                    if (r_idx == ett_pkg::LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx       = r_idx + ett_pkg::t_slot_idx'(1);
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = r_idx + ett_pkg::t_slot_idx'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.end_scan = 1'b1;
                    n_o_valid    = 1'b1;
                    n_kind       = ett_pkg::KIND_DONE;
                    n_slot_res   = '0;
                    n_tag_res    = '0;
                    n_last       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_expiry   <= n_expiry;
        r_wrap     <= n_wrap;
        r_wait     <= n_wait;
        r_tag_in   <= n_tag_in;
        r_slot_in  <= n_slot_in;
        r_now      <= n_now;
        r_kind     <= n_kind;
        r_slot_res <= n_slot_res;
        r_tag_res  <= n_tag_res;
        r_last     <= n_last;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_o_valid;
    assign o_kind             = r_kind;
    assign o_slot_res         = r_slot_res;
    assign o_callback_tag_res = r_tag_res;
    assign o_last             = r_last;

endmodule

// ===== src/ett_checker.sv =====
// ett_checker: port-level checks for expiring_timer_table and its bind
// depends on ett_pkg
module ett_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [3:0]  o_slot_res,
    input logic [15:0] o_callback_tag_res,
    input logic        o_last
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_slot_res) && $stable(o_callback_tag_res) && $stable(o_last))
        else $error("stalled result word changed");

    // only fired words leave a command open
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind != ett_pkg::KIND_FIRED)))
        else $error("last flag does not match word kind");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while busy");

    // done marker carries no slot or tag
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == ett_pkg::KIND_DONE |->
            o_slot_res == '0 && o_callback_tag_res == '0)
        else $error("done word carries slot or tag");

endmodule

bind expiring_timer_table ett_checker u_ett_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_kind             (o_kind),
    .o_slot_res         (o_slot_res),
    .o_callback_tag_res (o_callback_tag_res),
    .o_last             (o_last)
);
